[rtl/awb_gain_from_ratio_macros.svh]
// Assertion macros for the white-balance gain block.
// Used by the checker; expects clk and arst_n in scope.
`ifndef AWB_GAIN_FROM_RATIO_MACROS_SVH
`define AWB_GAIN_FROM_RATIO_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define AWB_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("awb gain assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define AWB_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("awb gain assertion failed");

`endif

[rtl/awbg_pkg.sv]
// Shared types and constants of the white-balance gain block.
// No dependencies.
package awbg_pkg;

	localparam int RATIO_W = 10;
	localparam int GAIN_W  = 16;
	localparam int RAW_W   = 20;
	localparam int LATENCY = 12;

	localparam logic [RATIO_W-1:0] UNITY_RAW  = 10'd1000;
	localparam logic [GAIN_W-1:0]  UNITY_GAIN = 16'h0400;
	localparam logic [GAIN_W-1:0]  GAIN_MAX   = 16'hFFFF;
	// A gain saturates when raw >= base * 0x40 (1024 * raw / base >= 65536).
	localparam int SAT_SHIFT = 6;

	localparam logic [1:0] REG_RG_TYPICAL = 2'd0;
	localparam logic [1:0] REG_BG_TYPICAL = 2'd1;

	typedef struct packed {
		logic [RATIO_W-1:0] rg_meas;
		logic [RATIO_W-1:0] bg_meas;
		logic               info_valid;
	} req_t;

	typedef struct packed {
		logic [GAIN_W-1:0] red_gain;
		logic [GAIN_W-1:0] green_gain;
		logic [GAIN_W-1:0] blue_gain;
		logic              red_apply;
		logic              green_apply;
		logic              blue_apply;
		logic              div_error;
	} res_t;

endpackage

[rtl/awb_gain_from_ratio.sv]
// Top level of the white-balance gain block: a fully pipelined datapath.
// Depends on awbg_pkg.
//
// The block takes one item per clock and never asserts busy. Each result
// is taken with the done strobe; its path runs through the two pipelined
// restoring dividers (five stages of four quotient bits for the raw gains,
// four stages of four bits for the scaled gains) plus an entry stage, a
// base-selection stage and the output register. Results cannot be held off,
// so the pipeline never stalls. Configuration writes are always ready and
// take effect on the next item.
module awb_gain_from_ratio (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  awbg_pkg::req_t       req,
	output logic                 done,
	output awbg_pkg::res_t       res,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [1:0]           cfg_index,
	input  logic [9:0]           cfg_data
);
	import awbg_pkg::*;

	typedef struct packed {
		logic [RATIO_W-1:0] r_div;
		logic [RATIO_W-1:0] b_div;
		logic [RATIO_W-1:0] r_rem;
		logic [RATIO_W-1:0] b_rem;
		logic [RAW_W-1:0]   r_wq;
		logic [RAW_W-1:0]   b_wq;
		logic               info;
		logic               err;
	} d1_t;

	typedef struct packed {
		logic [RATIO_W-1:0] base;
		logic [RATIO_W-1:0] r_rem;
		logic [RATIO_W-1:0] g_rem;
		logic [RATIO_W-1:0] b_rem;
		logic [GAIN_W-1:0]  r_wq;
		logic [GAIN_W-1:0]  g_wq;
		logic [GAIN_W-1:0]  b_wq;
		logic               r_sat;
		logic               g_sat;
		logic               b_sat;
		logic               info;
		logic               err;
	} d2_t;

	// One restoring step: returns the new remainder and the quotient bit.
	function automatic logic [RATIO_W:0] div_bit(logic [RATIO_W-1:0] rem, logic nb,
			logic [RATIO_W-1:0] d);
		logic [RATIO_W:0] t;
		logic [RATIO_W:0] diff;
		t    = {rem, nb};
		diff = t - {1'b0, d};
		if (t >= {1'b0, d}) begin
			div_bit = {diff[RATIO_W-1:0], 1'b1};
		end else begin
			div_bit = {t[RATIO_W-1:0], 1'b0};
		end
	endfunction

	function automatic d1_t step_d1(d1_t a);
		d1_t o;
		logic [RATIO_W:0] r;
		o = a;
		for (int i = 0; i < 4; i++) begin
			r       = div_bit(o.r_rem, o.r_wq[RAW_W-1], o.r_div);
			o.r_rem = r[RATIO_W:1];
			o.r_wq  = {o.r_wq[RAW_W-2:0], r[0]};
			r       = div_bit(o.b_rem, o.b_wq[RAW_W-1], o.b_div);
			o.b_rem = r[RATIO_W:1];
			o.b_wq  = {o.b_wq[RAW_W-2:0], r[0]};
		end
		step_d1 = o;
	endfunction

	function automatic d2_t step_d2(d2_t a);
		d2_t o;
		logic [RATIO_W:0] r;
		o = a;
		for (int i = 0; i < 4; i++) begin
			r       = div_bit(o.r_rem, o.r_wq[GAIN_W-1], o.base);
			o.r_rem = r[RATIO_W:1];
			o.r_wq  = {o.r_wq[GAIN_W-2:0], r[0]};
			r       = div_bit(o.g_rem, o.g_wq[GAIN_W-1], o.base);
			o.g_rem = r[RATIO_W:1];
			o.g_wq  = {o.g_wq[GAIN_W-2:0], r[0]};
			r       = div_bit(o.b_rem, o.b_wq[GAIN_W-1], o.base);
			o.b_rem = r[RATIO_W:1];
			o.b_wq  = {o.b_wq[GAIN_W-2:0], r[0]};
		end
		step_d2 = o;
	endfunction

	logic [RATIO_W-1:0] rg_typical_q;
	logic [RATIO_W-1:0] bg_typical_q;
	logic [11:1]        vld_s;
	d1_t                d1_s [1:6];
	d2_t                d2_s [7:11];
	d1_t                d1_in;
	d2_t                d2_in;
	res_t               res_nxt;
	logic               accept;

	logic [RAW_W-1:0]   r_raw;
	logic [RAW_W-1:0]   b_raw;
	logic [RAW_W-1:0]   raw_min;
	logic [RATIO_W-1:0] base;
	logic [RAW_W-1:0]   base_sh;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rg_typical_q <= '0;
			bg_typical_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == REG_RG_TYPICAL) rg_typical_q <= cfg_data;
			if (cfg_index == REG_BG_TYPICAL) bg_typical_q <= cfg_data;
		end
	end

	always_comb begin
		d1_in.r_div = req.rg_meas;
		d1_in.b_div = req.bg_meas;
		d1_in.r_rem = '0;
		d1_in.b_rem = '0;
		d1_in.r_wq  = RAW_W'(rg_typical_q) * RAW_W'(UNITY_RAW);
		d1_in.b_wq  = RAW_W'(bg_typical_q) * RAW_W'(UNITY_RAW);
		d1_in.info  = req.info_valid;
		d1_in.err   = (req.rg_meas == '0) || (req.bg_meas == '0);
	end

	// Base selection and setup of the scaling division. The base never
	// exceeds 1000, so it fits the ratio width.
	always_comb begin
		r_raw   = d1_s[6].r_wq;
		b_raw   = d1_s[6].b_wq;
		raw_min = (r_raw < b_raw) ? r_raw : b_raw;
		if (r_raw < RAW_W'(UNITY_RAW) || b_raw < RAW_W'(UNITY_RAW)) begin
			base = raw_min[RATIO_W-1:0];
		end else begin
			base = UNITY_RAW;
		end
		base_sh     = RAW_W'(base) << SAT_SHIFT;
		d2_in.base  = base;
		d2_in.r_sat = r_raw >= base_sh;
		d2_in.b_sat = b_raw >= base_sh;
		d2_in.g_sat = RAW_W'(UNITY_RAW) >= base_sh;
		// Without saturation raw >> 6 is below base, so it seeds the remainder.
		d2_in.r_rem = r_raw[SAT_SHIFT+RATIO_W-1:SAT_SHIFT];
		d2_in.b_rem = b_raw[SAT_SHIFT+RATIO_W-1:SAT_SHIFT];
		d2_in.g_rem = UNITY_RAW >> SAT_SHIFT;
		d2_in.r_wq  = {r_raw[SAT_SHIFT-1:0], (GAIN_W-SAT_SHIFT)'(0)};
		d2_in.b_wq  = {b_raw[SAT_SHIFT-1:0], (GAIN_W-SAT_SHIFT)'(0)};
		d2_in.g_wq  = {UNITY_RAW[SAT_SHIFT-1:0], (GAIN_W-SAT_SHIFT)'(0)};
		d2_in.info  = d1_s[6].info;
		d2_in.err   = d1_s[6].err || (base == '0);
	end

	always_comb begin
		d2_t f;
		f = d2_s[11];
		res_nxt.red_gain   = f.err ? '0 : (f.r_sat ? GAIN_MAX : f.r_wq);
		res_nxt.green_gain = f.err ? '0 : (f.g_sat ? GAIN_MAX : f.g_wq);
		res_nxt.blue_gain  = f.err ? '0 : (f.b_sat ? GAIN_MAX : f.b_wq);
		res_nxt.red_apply   = f.info && !f.err && (res_nxt.red_gain > UNITY_GAIN);
		res_nxt.green_apply = f.info && !f.err && (res_nxt.green_gain > UNITY_GAIN);
		res_nxt.blue_apply  = f.info && !f.err && (res_nxt.blue_gain > UNITY_GAIN);
		res_nxt.div_error   = f.err;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
			done  <= 1'b0;
		end else begin
			vld_s <= {vld_s[10:1], accept};
			done  <= vld_s[11];
		end
	end

	always_ff @(posedge clk) begin
		d1_s[1] <= d1_in;
		for (int k = 2; k <= 6; k++) begin
			d1_s[k] <= step_d1(d1_s[k-1]);
		end
		d2_s[7] <= d2_in;
		for (int k = 8; k <= 11; k++) begin
			d2_s[k] <= step_d2(d2_s[k-1]);
		end
		res <= res_nxt;
	end

endmodule

[rtl/awbg_checker.sv]
// Port-level checker for the white-balance gain block, bound to its top level.
// Depends on awbg_pkg and awb_gain_from_ratio_macros.svh.
`include "awb_gain_from_ratio_macros.svh"

module awbg_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           start,
	input logic           busy,
	input logic           done,
	input awbg_pkg::res_t res
);
	import awbg_pkg::*;

	logic gains_zero;
	logic applies_low;
	logic applies_ok;

	assign gains_zero  = (res.red_gain == '0) && (res.green_gain == '0)
		&& (res.blue_gain == '0);
	assign applies_low = !res.red_apply && !res.green_apply && !res.blue_apply;
	assign applies_ok  = (!res.red_apply || res.red_gain > UNITY_GAIN)
		&& (!res.green_apply || res.green_gain > UNITY_GAIN)
		&& (!res.blue_apply || res.blue_gain > UNITY_GAIN);

	// Every accepted item is followed by a result, and no result comes without one.
	`AWB_ASSERT_NEXT(a_latency, start && !busy, ##(LATENCY-1) done)
	`AWB_ASSERT_NOW(a_no_orphan, done, $past(start && !busy, LATENCY))
	`AWB_ASSERT_NOW(a_err_zero, done && res.div_error, gains_zero && applies_low)
	`AWB_ASSERT_NOW(a_apply_gain, done && !applies_low, applies_ok)

endmodule

bind awb_gain_from_ratio awbg_checker u_awbg_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.res    (res)
);

[tb/sv/tb_awb_gain_from_ratio.sv]
// Self-checking testbench of the white-balance gain block awb_gain_from_ratio.
// Depends on awbg_pkg; predicts each result from the golden ratios and compares fields.
module tb_awb_gain_from_ratio;
	import awbg_pkg::*;

	class gain_scoreboard;
		logic [9:0] rg_golden;
		logic [9:0] bg_golden;
		res_t pending[$];
		int errors;

		function new();
			rg_golden = '0;
			bg_golden = '0;
			errors = 0;
		endfunction

		function logic [15:0] scaled(longint unsigned raw, longint unsigned base);
			longint unsigned g;
			g = (1024 * raw) / base;
			return (g > 65535) ? 16'hFFFF : g[15:0];
		endfunction

		function void note_item(req_t r);
			res_t e;
			longint unsigned r_raw, b_raw, base;
			e = '0;
			if (r.rg_meas == 0 || r.bg_meas == 0) begin
				e.div_error = 1'b1;
			end else begin
				r_raw = (longint'(rg_golden) * 1000) / r.rg_meas;
				b_raw = (longint'(bg_golden) * 1000) / r.bg_meas;
				if (r_raw < 1000 || b_raw < 1000)
					base = (r_raw < b_raw) ? r_raw : b_raw;
				else
					base = 1000;
				if (base == 0) begin
					e.div_error = 1'b1;
				end else begin
					e.red_gain = scaled(r_raw, base);
					e.green_gain = scaled(1000, base);
					e.blue_gain = scaled(b_raw, base);
					e.red_apply = r.info_valid && e.red_gain > 16'd1024;
					e.green_apply = r.info_valid && e.green_gain > 16'd1024;
					e.blue_apply = r.info_valid && e.blue_gain > 16'd1024;
				end
			end
			pending.push_back(e);
		endfunction

		function void check_result(res_t a);
			res_t e;
			if (pending.size() == 0) begin
				$error("result with no item outstanding");
				errors++;
				return;
			end
			e = pending.pop_front();
			if (a.red_gain !== e.red_gain) begin
				$error("red_gain expected %0d actual %0d", e.red_gain, a.red_gain); errors++;
			end
			if (a.green_gain !== e.green_gain) begin
				$error("green_gain expected %0d actual %0d", e.green_gain, a.green_gain); errors++;
			end
			if (a.blue_gain !== e.blue_gain) begin
				$error("blue_gain expected %0d actual %0d", e.blue_gain, a.blue_gain); errors++;
			end
			if (a.red_apply !== e.red_apply) begin
				$error("red_apply expected %0b actual %0b", e.red_apply, a.red_apply); errors++;
			end
			if (a.green_apply !== e.green_apply) begin
				$error("green_apply expected %0b actual %0b", e.green_apply, a.green_apply);
				errors++;
			end
			if (a.blue_apply !== e.blue_apply) begin
				$error("blue_apply expected %0b actual %0b", e.blue_apply, a.blue_apply); errors++;
			end
			if (a.div_error !== e.div_error) begin
				$error("div_error expected %0b actual %0b", e.div_error, a.div_error); errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	req_t req = '0;
	logic done;
	res_t res;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [1:0] cfg_index = '0;
	logic [9:0] cfg_data = '0;
	gain_scoreboard sb = new();
	longint cycles = 0;
	bit quiet = 1'b0;

	awb_gain_from_ratio DUT (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (arst_n && done)
			sb.check_result(res);
		if (cycles > 200000) begin
			$display("FAIL");
			$finish;
		end
	end

	task automatic write_reg(logic [1:0] idx, logic [9:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		if (idx == REG_RG_TYPICAL) sb.rg_golden = val;
		else sb.bg_golden = val;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Drops start, waits until every expected result is back, then lets the pipeline run empty.
	task automatic drain();
		@(negedge clk);
		start <= 1'b0;
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (LATENCY + 4) @(negedge clk);
	endtask

	task automatic send_item(logic [9:0] rg, logic [9:0] bg, logic iv);
		req_t r;
		r.rg_meas = rg;
		r.bg_meas = bg;
		r.info_valid = iv;
		@(negedge clk);
		if (!quiet && $urandom_range(0, 5) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 7)) @(negedge clk);
		end
		start <= 1'b1;
		req <= r;
		do @(posedge clk); while (busy);
		sb.note_item(r);
	endtask

	// Measured ratios mostly near the golden ones, sometimes anywhere.
	function automatic logic [9:0] near(logic [9:0] g);
		int v;
		if ($urandom_range(0, 3) == 0) return 10'($urandom_range(0, 1023));
		v = int'(g) + int'($urandom_range(0, 200)) - 100;
		if (v < 0) v = 0;
		if (v > 1023) v = 1023;
		return v[9:0];
	endfunction

	initial begin
		logic [9:0] golden_sets[6][2];
		golden_sets = '{'{10'd0, 10'd0}, '{10'd1023, 10'd1023}, '{10'd300, 10'd600},
			'{10'd1, 10'd1023}, '{10'd512, 10'd1}, '{10'd700, 10'd450}};
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		// Golden ratios still at reset: every nonzero measurement gives a zero base.
		send_item(10'd100, 10'd200, 1'b1);
		send_item(10'd0, 10'd5, 1'b1);
		drain();
		write_reg(REG_RG_TYPICAL, 10'd1023);
		write_reg(REG_BG_TYPICAL, 10'd1023);
		send_item(10'd1, 10'd1, 1'b1);       // saturated red and blue gains
		send_item(10'd1, 10'd1023, 1'b1);
		send_item(10'd1023, 10'd1, 1'b0);    // info not valid
		send_item(10'd1023, 10'd1023, 1'b1);
		send_item(10'd0, 10'd1023, 1'b1);    // zero measured ratio
		send_item(10'd1023, 10'd0, 1'b0);
		send_item(10'd512, 10'd511, 1'b1);
		send_item(10'h155, 10'h2AA, 1'b1);
		send_item(10'h2AA, 10'h155, 1'b0);
		drain();
		write_reg(REG_RG_TYPICAL, 10'd1);
		write_reg(REG_BG_TYPICAL, 10'd600);
		send_item(10'd1023, 10'd300, 1'b1);  // red raw gain zero, zero base
		send_item(10'd1, 10'd600, 1'b1);
		send_item(10'd2, 10'd1023, 1'b1);
		drain();
		for (int p = 0; p < 12; p++) begin
			int k;
			k = $urandom_range(0, 5);
			if (p < 6) k = p;
			write_reg(REG_RG_TYPICAL, (p >= 6 && k == 5) ? 10'($urandom) : golden_sets[k][0]);
			write_reg(REG_BG_TYPICAL, (p >= 6 && k == 5) ? 10'($urandom) : golden_sets[k][1]);
			if (p >= 10) quiet = 1'b1;
			repeat (80)
				send_item(near(sb.rg_golden), near(sb.bg_golden), $urandom_range(0, 3) != 0);
			drain();
		end
		if (sb.errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end
endmodule

[filelist.f]
+incdir+rtl
rtl/awbg_pkg.sv
rtl/awb_gain_from_ratio.sv
rtl/awbg_checker.sv
tb/sv/tb_awb_gain_from_ratio.sv
